// ===== rtl/core/lkf_pkg.sv =====
package lkf_pkg;

  // sizing
  localparam int MAX_STATE   = 8;
  localparam int MAX_MEASURE = 8;
  localparam int MAX_CONTROL = 8;
  localparam int FRAC_BITS   = 16;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 10;
  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = 56;

  // scratch memory regions, 64 words each, S takes regions 8 and 9
  localparam logic [3:0] RG_F   = 4'd0;
  localparam logic [3:0] RG_B   = 4'd1;
  localparam logic [3:0] RG_H   = 4'd2;
  localparam logic [3:0] RG_Q   = 4'd3;
  localparam logic [3:0] RG_R   = 4'd4;
  localparam logic [3:0] RG_P   = 4'd5;
  localparam logic [3:0] RG_FP  = 4'd6;
  localparam logic [3:0] RG_PP  = 4'd7;
  localparam logic [3:0] RG_PH  = 4'd10;
  localparam logic [3:0] RG_K   = 4'd11;
  localparam logic [3:0] RG_MK  = 4'd12;
  localparam logic [3:0] RG_VEC = 4'd13;
  localparam logic [2:0] S_BASE = 3'b100;

  // vector offsets inside the vector region
  localparam logic [5:0] OFF_X  = 6'd0;
  localparam logic [5:0] OFF_U  = 6'd8;
  localparam logic [5:0] OFF_Z  = 6'd16;
  localparam logic [5:0] OFF_XP = 6'd24;
  localparam logic [5:0] OFF_Y  = 6'd32;
  localparam int VEC_RESET_N    = 24;

  // accumulator operations
  localparam logic [2:0] ACC_HOLD = 3'd0;
  localparam logic [2:0] ACC_ZERO = 3'd1;
  localparam logic [2:0] ACC_ONE  = 3'd2;
  localparam logic [2:0] ACC_MEM  = 3'd3;
  localparam logic [2:0] ACC_ADD  = 3'd4;
  localparam logic [2:0] ACC_SUB  = 3'd5;

  // write data select
  localparam logic [2:0] WS_LOAD = 3'd0;
  localparam logic [2:0] WS_ACC  = 3'd1;
  localparam logic [2:0] WS_DIV  = 3'd2;
  localparam logic [2:0] WS_RDA  = 3'd3;
  localparam logic [2:0] WS_RDB  = 3'd4;

  // input commands and matrix ids
  localparam logic [1:0] CMD_LOAD_MAT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_CTL  = 2'd1;
  localparam logic [1:0] CMD_LOAD_MEAS = 2'd2;
  localparam logic [1:0] CMD_STEP      = 2'd3;

  localparam logic [2:0] MID_F   = 3'd0;
  localparam logic [2:0] MID_B   = 3'd1;
  localparam logic [2:0] MID_H   = 3'd2;
  localparam logic [2:0] MID_Q   = 3'd3;
  localparam logic [2:0] MID_R   = 3'd4;
  localparam logic [2:0] MID_X   = 3'd5;
  localparam logic [2:0] MID_P   = 3'd6;
  localparam logic [2:0] MID_NONE = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_STATE   = 2'd0;
  localparam logic [1:0] CFG_MEASURE = 2'd1;
  localparam logic [1:0] CFG_CONTROL = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [2:0]        wr_sel;
    logic [2:0]        acc_op;
    logic              mul_en;
    logic              mul_sel_f;
    logic              rnd_en;
    logic              f_cap;
    logic              piv_cap;
    logic              best_first;
    logic              best_upd;
    logic              div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic abs_gt;
    logic abs_zero;
    logic best_zero;
    logic div_busy;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] addr_mat(input logic [3:0] rg, input logic [2:0] r,
                                                 input logic [2:0] c);
    return {rg, r, c};
  endfunction

  function automatic logic [ADDR_W-1:0] addr_s(input logic [2:0] r, input logic [3:0] c);
    return {S_BASE, r, c};
  endfunction

  function automatic logic [ADDR_W-1:0] addr_vec(input logic [5:0] off);
    return {RG_VEC, off};
  endfunction

endpackage

// ===== rtl/core/lkf_div.sv =====
module lkf_div import lkf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              busy,
  output logic [DATA_W-1:0] quot
);

  localparam int DVD_W = DATA_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  q;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dabs;
  logic [CNT_W-1:0]  cnt;
  logic              neg;

  logic [DATA_W-1:0] nabs;
  logic [DATA_W-1:0] dabs_in;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // magnitudes of the operands
  assign nabs    = num[DATA_W-1] ? DATA_W'(-num) : num;
  assign dabs_in = den[DATA_W-1] ? DATA_W'(-den) : den;

  // restoring step, one quotient bit per cycle
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dabs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {1'b0, nabs, {FRAC_BITS{1'b0}}} + DVD_W'(dabs_in[DATA_W-1:1]);
      dabs <= dabs_in;
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      rem  <= '0;
      q    <= '0;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      rem <= ge ? DATA_W'(rem_sh - {1'b0, dabs}) : rem_sh[DATA_W-1:0];
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      q   <= {q[DVD_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // signed, saturated quotient
  always_comb begin
    if (neg) begin
      if (q > (DVD_W'(1) << (DATA_W - 1))) begin
        quot = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        quot = DATA_W'(-q);
      end
    end else begin
      if (q > ((DVD_W'(1) << (DATA_W - 1)) - DVD_W'(1))) begin
        quot = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        quot = q[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/lkf_datapath.sv =====
module lkf_datapath import lkf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] load_value,
  output dp_stat_t                 stat,
  output logic        [DATA_W-1:0] rd_value
);

  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -(ACC_W'(64'sd1 <<< (DATA_W - 1)));

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rda;
  logic [DATA_W-1:0] rdb;
  logic              mask_a;
  logic              mask_b;
  logic [VEC_RESET_N-1:0] vvalid;

  logic signed [DATA_W-1:0] a_val;
  logic signed [DATA_W-1:0] b_val;
  logic signed [DATA_W-1:0] f;
  logic signed [DATA_W-1:0] piv;
  logic        [DATA_W-1:0] best;
  logic        [DATA_W-1:0] abs_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] acc_sat;
  logic signed [DATA_W-1:0] op_a;
  logic        [DATA_W-1:0] wr_data;
  logic        [DATA_W-1:0] quot;
  logic                     div_busy;

  // vector entries not yet written read as zero
  function automatic logic vec_masked(input logic [ADDR_W-1:0] ad,
                                      input logic [VEC_RESET_N-1:0] vv);
    return (ad[ADDR_W-1:6] == RG_VEC) && !ad[5] && (ad[4:3] != 2'b11) && !vv[ad[4:0]];
  endfunction

  function automatic logic vec_tracked(input logic [ADDR_W-1:0] ad);
    return (ad[ADDR_W-1:6] == RG_VEC) && !ad[5] && (ad[4:3] != 2'b11);
  endfunction

  // scratch memory, two read ports and one write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rda    <= mem[cmd.rd_addr_a];
      rdb    <= mem[cmd.rd_addr_b];
      mask_a <= vec_masked(cmd.rd_addr_a, vvalid);
      mask_b <= vec_masked(cmd.rd_addr_b, vvalid);
    end
  end

  // written marks for the zero-reset vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
    end else if (cmd.wr_en && vec_tracked(cmd.wr_addr)) begin
      vvalid[cmd.wr_addr[4:0]] <= 1'b1;
    end
  end

  assign a_val    = mask_a ? '0 : rda;
  assign b_val    = mask_b ? '0 : rdb;
  assign rd_value = a_val;

  // write data select
  always_comb begin
    unique case (cmd.wr_sel)
      WS_LOAD: wr_data = load_value;
      WS_ACC:  wr_data = acc_sat;
      WS_DIV:  wr_data = quot;
      WS_RDA:  wr_data = a_val;
      WS_RDB:  wr_data = b_val;
      default: wr_data = acc_sat;
    endcase
  end

  // multiply, round, accumulate
  assign op_a = cmd.mul_sel_f ? f : a_val;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * b_val;
    end
    if (cmd.rnd_en) begin
      term <= TERM_W'((prod + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end
    unique case (cmd.acc_op)
      ACC_ZERO: acc <= '0;
      ACC_ONE:  acc <= ACC_W'(64'sd1 <<< FRAC_BITS);
      ACC_MEM:  acc <= ACC_W'(a_val);
      ACC_ADD:  acc <= acc + ACC_W'(term);
      ACC_SUB:  acc <= acc - ACC_W'(term);
      default:  acc <= acc;
    endcase
  end

  always_comb begin
    if (acc > ACC_MAX) begin
      acc_sat = ACC_MAX[DATA_W-1:0];
    end else if (acc < ACC_MIN) begin
      acc_sat = ACC_MIN[DATA_W-1:0];
    end else begin
      acc_sat = acc[DATA_W-1:0];
    end
  end

  // elimination factor, pivot and pivot search
  assign abs_a = a_val[DATA_W-1] ? DATA_W'(-a_val) : a_val;

  always_ff @(posedge clk) begin
    if (cmd.f_cap) begin
      f <= a_val;
    end
    if (cmd.piv_cap) begin
      piv <= a_val;
    end
    if (cmd.best_first || (cmd.best_upd && stat.abs_gt)) begin
      best <= abs_a;
    end
  end

  lkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (a_val),
    .den   (piv),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign stat.abs_gt    = abs_a > best;
  assign stat.abs_zero  = abs_a == '0;
  assign stat.best_zero = best == '0;
  assign stat.div_busy  = div_busy;

endmodule

// ===== rtl/core/lkf_ctrl.sv =====
module lkf_ctrl import lkf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  logic [2:0] matrix_id,
  input  logic [2:0] row,
  input  logic [2:0] column,
  output logic       busy,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       result_valid,
  output logic [2:0] state_index,
  output logic       last,
  output logic       singular
);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_BEGIN   = 5'd1;
  localparam logic [4:0] S_INIT_RD = 5'd2;
  localparam logic [4:0] S_INIT    = 5'd3;
  localparam logic [4:0] S_RD      = 5'd4;
  localparam logic [4:0] S_MUL     = 5'd5;
  localparam logic [4:0] S_RND     = 5'd6;
  localparam logic [4:0] S_ACC     = 5'd7;
  localparam logic [4:0] S_WR      = 5'd8;
  localparam logic [4:0] S_NEXT    = 5'd9;
  localparam logic [4:0] S_SR_RD   = 5'd10;
  localparam logic [4:0] S_SR_CMP  = 5'd11;
  localparam logic [4:0] S_SW_RD   = 5'd12;
  localparam logic [4:0] S_SW_W1   = 5'd13;
  localparam logic [4:0] S_SW_W2   = 5'd14;
  localparam logic [4:0] S_PV_RD   = 5'd15;
  localparam logic [4:0] S_PV_CAP  = 5'd16;
  localparam logic [4:0] S_N_RD    = 5'd17;
  localparam logic [4:0] S_N_ST    = 5'd18;
  localparam logic [4:0] S_N_WT    = 5'd19;
  localparam logic [4:0] S_N_WR    = 5'd20;
  localparam logic [4:0] S_F_RD    = 5'd21;
  localparam logic [4:0] S_F_CAP   = 5'd22;
  localparam logic [4:0] S_O_RD    = 5'd23;
  localparam logic [4:0] S_O_OUT   = 5'd24;

  // phases of one filter step
  localparam logic [3:0] PH_FP  = 4'd0;
  localparam logic [3:0] PH_PP  = 4'd1;
  localparam logic [3:0] PH_PH  = 4'd2;
  localparam logic [3:0] PH_S   = 4'd3;
  localparam logic [3:0] PH_SI  = 4'd4;
  localparam logic [3:0] PH_GJ  = 4'd5;
  localparam logic [3:0] PH_GE  = 4'd6;
  localparam logic [3:0] PH_K   = 4'd7;
  localparam logic [3:0] PH_MK  = 4'd8;
  localparam logic [3:0] PH_P   = 4'd9;
  localparam logic [3:0] PH_XP  = 4'd10;
  localparam logic [3:0] PH_Y   = 4'd11;
  localparam logic [3:0] PH_X   = 4'd12;
  localparam logic [3:0] PH_OUT = 4'd13;

  logic [4:0] st;
  logic [3:0] phase;
  logic [2:0] i;
  logic [3:0] j;
  logic [4:0] l;
  logic [2:0] c;
  logic [2:0] p;
  logic       sing;
  logic [3:0] state_size;
  logic [3:0] measure_size;
  logic [3:0] control_size;

  logic [3:0] n;
  logic [3:0] m;
  logic [3:0] k;
  logic [3:0] ni;
  logic [4:0] nj;
  logic [4:0] nl;
  logic [2:0] j3;
  logic [2:0] l3;
  logic [2:0] lk;
  logic       l_lt_n;
  logic       i_last;
  logic       j_last;
  logic       l_last;
  logic       c_last;
  logic       ident;
  logic       init_mem;
  logic       sub;
  logic       use_f;
  logic       zero_next;
  logic [2:0] p_next;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [ADDR_W-1:0] init_addr;
  logic [ADDR_W-1:0] dest_addr;
  logic [ADDR_W-1:0] load_addr;
  logic              load_ok;

  // active sizes
  assign n = (state_size == 4'd0) ? 4'd1 :
             (state_size > 4'(MAX_STATE)) ? 4'(MAX_STATE) : state_size;
  assign m = (measure_size == 4'd0) ? 4'd1 :
             (measure_size > 4'(MAX_MEASURE)) ? 4'(MAX_MEASURE) : measure_size;
  assign k = (control_size > 4'(MAX_CONTROL)) ? 4'(MAX_CONTROL) : control_size;

  assign j3     = j[2:0];
  assign l3     = l[2:0];
  assign lk     = 3'(l - {1'b0, n});
  assign l_lt_n = l < {1'b0, n};
  assign i_last = ({1'b0, i} == ni - 4'd1);
  assign j_last = ({1'b0, j} == nj - 5'd1);
  assign l_last = (5'(l + 5'd1) == nl);
  assign c_last = ({1'b0, c} == m - 4'd1);

  // loop bounds and addresses of each phase
  always_comb begin
    a_addr    = '0;
    b_addr    = '0;
    init_addr = '0;
    dest_addr = '0;
    init_mem  = 1'b0;
    ident     = 1'b0;
    sub       = 1'b0;
    use_f     = 1'b0;
    nl        = '0;
    ni        = n;
    nj        = {1'b0, n};
    unique case (phase)
      PH_FP: begin
        a_addr    = addr_mat(RG_F, i, l3);
        b_addr    = addr_mat(RG_P, l3, j3);
        dest_addr = addr_mat(RG_FP, i, j3);
        nl        = {1'b0, n};
      end
      PH_PP: begin
        init_mem  = 1'b1;
        init_addr = addr_mat(RG_Q, i, j3);
        a_addr    = addr_mat(RG_FP, i, l3);
        b_addr    = addr_mat(RG_F, j3, l3);
        dest_addr = addr_mat(RG_PP, i, j3);
        nl        = {1'b0, n};
      end
      PH_PH: begin
        a_addr    = addr_mat(RG_PP, i, l3);
        b_addr    = addr_mat(RG_H, j3, l3);
        dest_addr = addr_mat(RG_PH, i, j3);
        nl        = {1'b0, n};
        nj        = {1'b0, m};
      end
      PH_S: begin
        init_mem  = 1'b1;
        init_addr = addr_mat(RG_R, i, j3);
        a_addr    = addr_mat(RG_H, i, l3);
        b_addr    = addr_mat(RG_PH, l3, j3);
        dest_addr = addr_s(i, {1'b0, j3});
        nl        = {1'b0, n};
        ni        = m;
        nj        = {1'b0, m};
      end
      PH_SI: begin
        ident     = 1'b1;
        dest_addr = addr_s(i, {1'b0, j3} + m);
        ni        = m;
        nj        = {1'b0, m};
      end
      PH_GJ: begin
        ni = m;
        nj = {m, 1'b0};
      end
      PH_GE: begin
        init_mem  = 1'b1;
        init_addr = addr_s(i, j);
        b_addr    = addr_s(c, j);
        dest_addr = addr_s(i, j);
        use_f     = 1'b1;
        sub       = 1'b1;
        nl        = 5'd1;
        ni        = m;
        nj        = {m, 1'b0};
      end
      PH_K: begin
        a_addr    = addr_mat(RG_PH, i, l3);
        b_addr    = addr_s(l3, {1'b0, j3} + m);
        dest_addr = addr_mat(RG_K, i, j3);
        nl        = sing ? 5'd0 : {1'b0, m};
        nj        = {1'b0, m};
      end
      PH_MK: begin
        ident     = 1'b1;
        sub       = 1'b1;
        a_addr    = addr_mat(RG_K, i, l3);
        b_addr    = addr_mat(RG_H, l3, j3);
        dest_addr = addr_mat(RG_MK, i, j3);
        nl        = {1'b0, m};
      end
      PH_P: begin
        a_addr    = addr_mat(RG_MK, i, l3);
        b_addr    = addr_mat(RG_PP, l3, j3);
        dest_addr = addr_mat(RG_P, i, j3);
        nl        = {1'b0, n};
      end
      PH_XP: begin
        a_addr    = l_lt_n ? addr_mat(RG_F, i, l3) : addr_mat(RG_B, i, lk);
        b_addr    = l_lt_n ? addr_vec(OFF_X + {3'b000, l3}) : addr_vec(OFF_U + {3'b000, lk});
        dest_addr = addr_vec(OFF_XP + {3'b000, i});
        nl        = {1'b0, n} + {1'b0, k};
        nj        = 5'd1;
      end
      PH_Y: begin
        init_mem  = 1'b1;
        init_addr = addr_vec(OFF_Z + {3'b000, i});
        a_addr    = addr_mat(RG_H, i, l3);
        b_addr    = addr_vec(OFF_XP + {3'b000, l3});
        dest_addr = addr_vec(OFF_Y + {3'b000, i});
        sub       = 1'b1;
        nl        = {1'b0, n};
        ni        = m;
        nj        = 5'd1;
      end
      PH_X: begin
        init_mem  = 1'b1;
        init_addr = addr_vec(OFF_XP + {3'b000, i});
        a_addr    = addr_mat(RG_K, i, l3);
        b_addr    = addr_vec(OFF_Y + {3'b000, l3});
        dest_addr = addr_vec(OFF_X + {3'b000, i});
        nl        = {1'b0, m};
        nj        = 5'd1;
      end
      PH_OUT: begin
        a_addr = addr_vec(OFF_X + {3'b000, i});
        nj     = 5'd1;
      end
      default: begin
        nj = 5'd1;
      end
    endcase
  end

  // load target address
  always_comb begin
    load_ok   = 1'b1;
    load_addr = '0;
    unique case (command)
      CMD_LOAD_MAT: begin
        unique case (matrix_id)
          MID_F:   load_addr = addr_mat(RG_F, row, column);
          MID_B:   load_addr = addr_mat(RG_B, row, column);
          MID_H:   load_addr = addr_mat(RG_H, row, column);
          MID_Q:   load_addr = addr_mat(RG_Q, row, column);
          MID_R:   load_addr = addr_mat(RG_R, row, column);
          MID_X:   load_addr = addr_vec(OFF_X + {3'b000, row});
          MID_P:   load_addr = addr_mat(RG_P, row, column);
          MID_NONE: load_ok  = 1'b0;
          default: load_ok   = 1'b0;
        endcase
      end
      CMD_LOAD_CTL:  load_addr = addr_vec(OFF_U + {3'b000, row});
      CMD_LOAD_MEAS: load_addr = addr_vec(OFF_Z + {3'b000, row});
      default:       load_ok   = 1'b0;
    endcase
  end

  // pivot search outcome of the current row
  assign p_next    = (i != c && stat.abs_gt) ? i : p;
  assign zero_next = (i == c) ? stat.abs_zero : (!stat.abs_gt && stat.best_zero);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_size   <= 4'd4;
      measure_size <= 4'd2;
      control_size <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STATE:   state_size   <= cfg_data;
        CFG_MEASURE: measure_size <= cfg_data;
        CFG_CONTROL: control_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      phase <= PH_FP;
      i     <= '0;
      j     <= '0;
      l     <= '0;
      c     <= '0;
      p     <= '0;
      sing  <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (start && command == CMD_STEP) begin
            phase <= PH_FP;
            i     <= '0;
            j     <= '0;
            c     <= '0;
            sing  <= 1'b0;
            st    <= S_BEGIN;
          end
        end
        S_BEGIN: begin
          unique case (phase)
            PH_GJ: begin
              i  <= c;
              p  <= c;
              st <= S_SR_RD;
            end
            PH_GE: begin
              if (i == c) begin
                st <= S_NEXT;
              end else if (j == 4'd0) begin
                st <= S_F_RD;
              end else begin
                l  <= '0;
                st <= S_INIT_RD;
              end
            end
            PH_OUT: st <= S_O_RD;
            default: begin
              l  <= '0;
              st <= S_INIT_RD;
            end
          endcase
        end
        S_INIT_RD: st <= S_INIT;
        S_INIT:    st <= (nl == 5'd0) ? S_WR : S_RD;
        S_RD:      st <= S_MUL;
        S_MUL:     st <= S_RND;
        S_RND:     st <= S_ACC;
        S_ACC: begin
          l  <= l + 5'd1;
          st <= l_last ? S_WR : S_RD;
        end
        S_WR: st <= S_NEXT;
        S_NEXT: begin
          if (!j_last && !(phase == PH_GE && i == c)) begin
            j  <= j + 4'd1;
            st <= S_BEGIN;
          end else begin
            j <= '0;
            if (!i_last) begin
              i  <= i + 3'd1;
              st <= S_BEGIN;
            end else begin
              i <= '0;
              unique case (phase)
                PH_GE: begin
                  if (c_last) begin
                    phase <= PH_K;
                  end else begin
                    c     <= c + 3'd1;
                    phase <= PH_GJ;
                  end
                  st <= S_BEGIN;
                end
                PH_SI: begin
                  phase <= PH_GJ;
                  st    <= S_BEGIN;
                end
                PH_OUT: st <= S_IDLE;
                default: begin
                  phase <= phase + 4'd1;
                  st    <= S_BEGIN;
                end
              endcase
            end
          end
        end
        S_SR_RD: st <= S_SR_CMP;
        S_SR_CMP: begin
          p <= p_next;
          if (!i_last) begin
            i  <= i + 3'd1;
            st <= S_SR_RD;
          end else if (zero_next) begin
            sing  <= 1'b1;
            phase <= PH_K;
            i     <= '0;
            j     <= '0;
            st    <= S_BEGIN;
          end else begin
            i  <= '0;
            j  <= '0;
            st <= (p_next != c) ? S_SW_RD : S_PV_RD;
          end
        end
        S_SW_RD: st <= S_SW_W1;
        S_SW_W1: st <= S_SW_W2;
        S_SW_W2: begin
          if (j_last) begin
            j  <= '0;
            st <= S_PV_RD;
          end else begin
            j  <= j + 4'd1;
            st <= S_SW_RD;
          end
        end
        S_PV_RD: st <= S_PV_CAP;
        S_PV_CAP: begin
          j  <= '0;
          st <= S_N_RD;
        end
        S_N_RD: st <= S_N_ST;
        S_N_ST: st <= S_N_WT;
        S_N_WT: begin
          if (!stat.div_busy) begin
            st <= S_N_WR;
          end
        end
        S_N_WR: begin
          if (j_last) begin
            j     <= '0;
            i     <= '0;
            phase <= PH_GE;
            st    <= S_BEGIN;
          end else begin
            j  <= j + 4'd1;
            st <= S_N_RD;
          end
        end
        S_F_RD: st <= S_F_CAP;
        S_F_CAP: begin
          l  <= '0;
          st <= S_INIT_RD;
        end
        S_O_RD:  st <= S_O_OUT;
        S_O_OUT: st <= S_NEXT;
        default: st <= S_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.acc_op = ACC_HOLD;
    cmd.wr_sel = WS_ACC;
    unique case (st)
      S_IDLE: begin
        cmd.wr_en   = start && command != CMD_STEP && load_ok;
        cmd.wr_addr = load_addr;
        cmd.wr_sel  = WS_LOAD;
      end
      S_INIT_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = init_addr;
      end
      S_INIT: begin
        if (init_mem) begin
          cmd.acc_op = ACC_MEM;
        end else if (ident && i == j3) begin
          cmd.acc_op = ACC_ONE;
        end else begin
          cmd.acc_op = ACC_ZERO;
        end
      end
      S_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = a_addr;
        cmd.rd_addr_b = b_addr;
      end
      S_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_f = use_f;
      end
      S_RND: cmd.rnd_en = 1'b1;
      S_ACC: cmd.acc_op = sub ? ACC_SUB : ACC_ADD;
      S_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = dest_addr;
        cmd.wr_sel  = WS_ACC;
      end
      S_SR_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = addr_s(i, {1'b0, c});
      end
      S_SR_CMP: begin
        cmd.best_first = (i == c);
        cmd.best_upd   = (i != c);
      end
      S_SW_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = addr_s(c, j);
        cmd.rd_addr_b = addr_s(p, j);
      end
      S_SW_W1: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_s(c, j);
        cmd.wr_sel  = WS_RDB;
      end
      S_SW_W2: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_s(p, j);
        cmd.wr_sel  = WS_RDA;
      end
      S_PV_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = addr_s(c, {1'b0, c});
      end
      S_PV_CAP: cmd.piv_cap = 1'b1;
      S_N_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = addr_s(c, j);
      end
      S_N_ST: cmd.div_start = 1'b1;
      S_N_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_s(c, j);
        cmd.wr_sel  = WS_DIV;
      end
      S_F_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = addr_s(i, {1'b0, c});
      end
      S_F_CAP: cmd.f_cap = 1'b1;
      S_O_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = a_addr;
      end
      default: ;
    endcase
  end

  assign busy         = st != S_IDLE;
  assign cfg_ready    = 1'b1;
  assign result_valid = st == S_O_OUT;
  assign state_index  = i;
  assign last         = i_last;
  assign singular     = sing;

endmodule

// ===== rtl/core/linear_kalman_filter_step.sv =====
// Linear Kalman filter step, saturating signed Q16.16.
// Input channel: a word is taken at a rising edge with start high and busy
// low. Load commands write one store or vector element in that cycle and
// leave busy low, so loads can follow back to back. A step command raises
// busy for the whole filter cycle.
// Result channel: a step emits one word per active state element, in index
// order, each on the result ports for one cycle with result_valid high;
// last marks the final element and singular flags a zero pivot. The
// receiver cannot stall, results are simply presented and taken.
// Configuration: cfg_valid/cfg_ready write state, measurement and control
// sizes; cfg_ready is always high, writes belong in idle time.
// Arithmetic: all products go through one multiply/round/accumulate unit,
// each passing read, multiply, round and accumulate states in turn, and
// each Gauss-Jordan normalization waits on a bit-serial divider. The step
// time grows with the cube of the state size. Results go out one word at a
// time at the end of the step.
// Reset: synchronous; sizes return to 4, 2, 0 and the state, control and
// measurement vectors read as zero until written. No clearing pass is run.
module linear_kalman_filter_step import lkf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic [2:0]               matrix_id,
  input  logic [2:0]               row,
  input  logic [2:0]               column,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [3:0]               cfg_data,
  output logic                     result_valid,
  output logic [2:0]               state_index,
  output logic signed [DATA_W-1:0] state_value,
  output logic                     last,
  output logic                     singular
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [DATA_W-1:0] rd_value;

  // sequencer
  lkf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .matrix_id    (matrix_id),
    .row          (row),
    .column       (column),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .cmd          (cmd),
    .result_valid (result_valid),
    .state_index  (state_index),
    .last         (last),
    .singular     (singular)
  );

  // memory and arithmetic
  lkf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .load_value (value),
    .stat       (stat),
    .rd_value   (rd_value)
  );

  assign state_value = rd_value;

endmodule

// ===== test/linear_kalman_filter_step_test.sv =====
module linear_kalman_filter_step_test;
  import lkf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // one emitted state element
  typedef struct {
    logic [2:0]  idx;
    logic [31:0] val;
    logic        lst;
    logic        sng;
  } state_word_t;

  // filter predictor plus queue of expected state words
  class kalman_scoreboard;
    logic [3:0] n_reg, m_reg, k_reg;
    int f_st[8][8], b_st[8][8], h_st[8][8], q_st[8][8], r_st[8][8], p_st[8][8];
    int x_v[8], u_v[8], z_v[8];
    bit f_ok[8][8], b_ok[8][8], h_ok[8][8], q_ok[8][8], r_ok[8][8], p_ok[8][8];
    state_word_t expected_states[$];
    int errors;

    function new();
      n_reg = 4;
      m_reg = 2;
      k_reg = 0;
      errors = 0;
      foreach (x_v[i]) begin
        x_v[i] = 0;
        u_v[i] = 0;
        z_v[i] = 0;
      end
    endfunction

    function int eff_n();
      return (n_reg < 1) ? 1 : (n_reg > MAX_STATE) ? MAX_STATE : n_reg;
    endfunction

    function int eff_m();
      return (m_reg < 1) ? 1 : (m_reg > MAX_MEASURE) ? MAX_MEASURE : m_reg;
    endfunction

    function int eff_k();
      return (k_reg > MAX_CONTROL) ? MAX_CONTROL : k_reg;
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // product rounded half up, floor shift
    function longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // quotient rounded to nearest, ties away from zero
    function longint divq(longint a, longint b);
      longint unsigned na, nb, q;
      longint r;
      na = longint'(a < 0 ? -a : a) << FRAC_BITS;
      nb = longint'(b < 0 ? -b : b);
      q = (na + nb / 2) / nb;
      r = longint'(q);
      if ((a < 0) != (b < 0)) r = -r;
      return sat(r);
    endfunction

    function void write_size(logic [1:0] idx, logic [3:0] d);
      case (idx)
        CFG_STATE:   n_reg = d;
        CFG_MEASURE: m_reg = d;
        CFG_CONTROL: k_reg = d;
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] cmd, logic [2:0] id, logic [2:0] r, logic [2:0] c,
                            logic [31:0] v);
      int w;
      w = int'(v);
      case (cmd)
        CMD_LOAD_MAT: begin
          case (id)
            MID_F: begin f_st[r][c] = w; f_ok[r][c] = 1; end
            MID_B: begin b_st[r][c] = w; b_ok[r][c] = 1; end
            MID_H: begin h_st[r][c] = w; h_ok[r][c] = 1; end
            MID_Q: begin q_st[r][c] = w; q_ok[r][c] = 1; end
            MID_R: begin r_st[r][c] = w; r_ok[r][c] = 1; end
            MID_X: x_v[r] = w;
            MID_P: begin p_st[r][c] = w; p_ok[r][c] = 1; end
            default: ;
          endcase
        end
        CMD_LOAD_CTL:  u_v[r] = w;
        CMD_LOAD_MEAS: z_v[r] = w;
        default: filter_cycle();
      endcase
    endfunction

    // one predict and correct pass, queues the n state words
    function void filter_cycle();
      longint fp[8][8], pp[8][8], ph[8][8], s[8][16], gn[8][8], mk[8][8];
      longint xp[8], y[8];
      longint a, t, piv, best, f;
      int n, m, k, p;
      bit sing;
      state_word_t sw;
      n = eff_n();
      m = eff_m();
      k = eff_k();
      sing = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          a = 0;
          for (int l = 0; l < n; l++) a += mulq(f_st[i][l], p_st[l][j]);
          fp[i][j] = sat(a);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          a = q_st[i][j];
          for (int l = 0; l < n; l++) a += mulq(fp[i][l], f_st[j][l]);
          pp[i][j] = sat(a);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < m; j++) begin
          a = 0;
          for (int l = 0; l < n; l++) a += mulq(pp[i][l], h_st[j][l]);
          ph[i][j] = sat(a);
        end
      for (int i = 0; i < m; i++)
        for (int j = 0; j < m; j++) begin
          a = r_st[i][j];
          for (int l = 0; l < n; l++) a += mulq(h_st[i][l], ph[l][j]);
          s[i][j] = sat(a);
          s[i][m + j] = (i == j) ? (64'sd1 <<< FRAC_BITS) : 0;
        end
      // gauss-jordan with largest-magnitude pivot, first row on a tie
      for (int c = 0; c < m; c++) begin
        p = c;
        best = s[c][c] < 0 ? -s[c][c] : s[c][c];
        for (int i = c + 1; i < m; i++) begin
          a = s[i][c] < 0 ? -s[i][c] : s[i][c];
          if (a > best) begin
            best = a;
            p = i;
          end
        end
        if (best == 0) begin
          sing = 1;
          break;
        end
        if (p != c)
          for (int j = 0; j < 2 * m; j++) begin
            t = s[c][j];
            s[c][j] = s[p][j];
            s[p][j] = t;
          end
        piv = s[c][c];
        for (int j = 0; j < 2 * m; j++) s[c][j] = divq(s[c][j], piv);
        for (int i = 0; i < m; i++) begin
          if (i == c) continue;
          f = s[i][c];
          for (int j = 0; j < 2 * m; j++) s[i][j] = sat(s[i][j] - mulq(f, s[c][j]));
        end
      end
      // gain, zero when singular
      for (int i = 0; i < n; i++)
        for (int j = 0; j < m; j++) begin
          a = 0;
          if (!sing)
            for (int l = 0; l < m; l++) a += mulq(ph[i][l], s[l][m + j]);
          gn[i][j] = sat(a);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          a = (i == j) ? (64'sd1 <<< FRAC_BITS) : 0;
          for (int l = 0; l < m; l++) a -= mulq(gn[i][l], h_st[l][j]);
          mk[i][j] = sat(a);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          a = 0;
          for (int l = 0; l < n; l++) a += mulq(mk[i][l], pp[l][j]);
          p_st[i][j] = int'(sat(a));
        end
      // prediction and correction of the estimate
      for (int i = 0; i < n; i++) begin
        a = 0;
        for (int l = 0; l < n; l++) a += mulq(f_st[i][l], x_v[l]);
        for (int l = 0; l < k; l++) a += mulq(b_st[i][l], u_v[l]);
        xp[i] = sat(a);
      end
      for (int j = 0; j < m; j++) begin
        a = z_v[j];
        for (int l = 0; l < n; l++) a -= mulq(h_st[j][l], xp[l]);
        y[j] = sat(a);
      end
      for (int i = 0; i < n; i++) begin
        a = xp[i];
        for (int l = 0; l < m; l++) a += mulq(gn[i][l], y[l]);
        x_v[i] = int'(sat(a));
        sw.idx = i[2:0];
        sw.val = x_v[i];
        sw.lst = (i == n - 1);
        sw.sng = sing;
        expected_states.push_back(sw);
      end
    endfunction

    function void check_word(logic [2:0] idx, logic [31:0] val, logic lst, logic sng);
      state_word_t e;
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected state word, expected none, actual idx %0d value %h",
                 $time, idx, val);
        errors++;
        return;
      end
      e = expected_states.pop_front();
      if (idx !== e.idx) begin
        $display("%0t: state_index expected %0d actual %0d", $time, e.idx, idx);
        errors++;
      end
      if (val !== e.val) begin
        $display("%0t: state_value expected %h actual %h", $time, e.val, val);
        errors++;
      end
      if (lst !== e.lst) begin
        $display("%0t: last expected %b actual %b", $time, e.lst, lst);
        errors++;
      end
      if (sng !== e.sng) begin
        $display("%0t: singular expected %b actual %b", $time, e.sng, sng);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy;
  logic [1:0] command;
  logic [2:0] matrix_id, row, column;
  logic signed [31:0] value;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  logic result_valid;
  logic [2:0] state_index;
  logic signed [31:0] state_value;
  logic last, singular;

  kalman_scoreboard sb;
  bit gaps_on;
  int cycles;

  linear_kalman_filter_step uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .matrix_id(matrix_id), .row(row), .column(column), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .state_index(state_index), .state_value(state_value),
    .last(last), .singular(singular)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_kalman_filter_step test failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk)
    if (!rst && result_valid) sb.check_word(state_index, state_value, last, singular);

  // mostly small well-behaved values, some full range and extremes
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    if (sel < 95) return $urandom;
    case ($urandom_range(0, 2))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      default: return 32'h0;
    endcase
  endfunction

  // one input word, with an optional gap in front
  task automatic send_word(logic [1:0] cmd, logic [2:0] id, logic [2:0] r, logic [2:0] c,
                           logic [31:0] v);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < 26) begin
      start = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1;
    command = cmd;
    matrix_id = id;
    row = r;
    column = c;
    value = v;
    do @(posedge clk); while (busy);
    sb.note_item(cmd, id, r, c, v);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (sb.expected_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] d);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_size(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // load every element a step will read that was never written
  task automatic fill_missing();
    int n, m, k;
    n = sb.eff_n();
    m = sb.eff_m();
    k = sb.eff_k();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!sb.f_ok[i][j]) send_word(CMD_LOAD_MAT, MID_F, 3'(i), 3'(j), pick_value());
        if (!sb.q_ok[i][j]) send_word(CMD_LOAD_MAT, MID_Q, 3'(i), 3'(j), pick_value());
        if (!sb.p_ok[i][j]) send_word(CMD_LOAD_MAT, MID_P, 3'(i), 3'(j), pick_value());
      end
      for (int j = 0; j < k; j++)
        if (!sb.b_ok[i][j]) send_word(CMD_LOAD_MAT, MID_B, 3'(i), 3'(j), pick_value());
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++)
        if (!sb.h_ok[i][j]) send_word(CMD_LOAD_MAT, MID_H, 3'(i), 3'(j), pick_value());
      for (int j = 0; j < m; j++)
        if (!sb.r_ok[i][j]) send_word(CMD_LOAD_MAT, MID_R, 3'(i), 3'(j), pick_value());
    end
  endtask

  // random loads and steps at the current sizes
  task automatic run_phase(int items);
    int cnt, steps, max_steps, sel;
    cnt = 0;
    steps = 0;
    max_steps = (sb.eff_n() >= 6 || sb.eff_m() >= 6) ? 3 : 8;
    while (cnt < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 20 && steps < max_steps) begin
        fill_missing();
        send_word(CMD_STEP, 3'($urandom), 3'($urandom), 3'($urandom), $urandom);
        steps++;
        cnt++;
      end else if (sel < 25) begin
        send_word(CMD_LOAD_MAT, MID_NONE, 3'($urandom), 3'($urandom), $urandom);
      end else if (sel < 27) begin
        drain();
      end else begin
        case ($urandom_range(0, 2))
          0: send_word(CMD_LOAD_MAT, 3'($urandom_range(0, 6)), 3'($urandom), 3'($urandom),
                       pick_value());
          1: send_word(CMD_LOAD_CTL, 3'($urandom), 3'($urandom), 3'($urandom), pick_value());
          default: send_word(CMD_LOAD_MEAS, 3'($urandom), 3'($urandom), 3'($urandom),
                             pick_value());
        endcase
        cnt++;
      end
    end
  endtask

  task automatic set_sizes(logic [3:0] s, logic [3:0] m, logic [3:0] c);
    drain();
    write_reg(CFG_STATE, s);
    write_reg(CFG_MEASURE, m);
    write_reg(CFG_CONTROL, c);
  endtask

  initial begin
    logic [3:0] plan[9][3];
    sb = new();
    cycles = 0;
    gaps_on = 1;
    rst = 1;
    start = 0;
    command = CMD_LOAD_MAT;
    matrix_id = MID_F;
    row = 0;
    column = 0;
    value = 0;
    cfg_valid = 0;
    cfg_index = CFG_STATE;
    cfg_data = 0;
    plan = '{'{4'd4, 4'd2, 4'd0}, '{4'd1, 4'd1, 4'd0}, '{4'd8, 4'd8, 4'd8},
             '{4'd2, 4'd3, 4'd1}, '{4'd0, 4'd0, 4'd15}, '{4'd15, 4'd15, 4'd0},
             '{4'd3, 4'd2, 4'd2}, '{4'd6, 4'd4, 4'd5}, '{4'd1, 4'd8, 4'd3}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: scalar filter with control term
    set_sizes(4'd1, 4'd1, 4'd1);
    send_word(CMD_LOAD_MAT, MID_F, 0, 0, 32'h0001_0000);
    send_word(CMD_LOAD_MAT, MID_B, 0, 0, 32'h0000_8000);
    send_word(CMD_LOAD_MAT, MID_H, 0, 0, 32'h0001_0000);
    send_word(CMD_LOAD_MAT, MID_Q, 0, 0, 32'h0000_1000);
    send_word(CMD_LOAD_MAT, MID_R, 0, 0, 32'h0000_4000);
    send_word(CMD_LOAD_MAT, MID_P, 0, 0, 32'h0001_0000);
    send_word(CMD_LOAD_MAT, MID_X, 0, 0, 32'h0002_0000);
    send_word(CMD_LOAD_CTL, 0, 0, 0, 32'h0001_0000);
    send_word(CMD_LOAD_MEAS, 0, 0, 0, 32'h0003_0000);
    send_word(CMD_STEP, 0, 0, 0, 0);
    // zero innovation covariance gives a singular inversion
    send_word(CMD_LOAD_MAT, MID_H, 0, 0, 32'h0);
    send_word(CMD_LOAD_MAT, MID_R, 0, 0, 32'h0);
    send_word(CMD_STEP, 7, 7, 7, 32'hFFFF_FFFF);
    // extremes, saturation, unused rows and an ignored matrix id
    send_word(CMD_LOAD_MAT, MID_F, 0, 0, 32'h7FFF_FFFF);
    send_word(CMD_LOAD_MAT, MID_X, 0, 0, 32'h8000_0000);
    send_word(CMD_LOAD_MAT, MID_X, 7, 7, 32'h7FFF_FFFF);
    send_word(CMD_LOAD_MAT, MID_P, 7, 7, 32'h8000_0000);
    send_word(CMD_LOAD_MAT, MID_NONE, 7, 7, 32'h7FFF_FFFF);
    send_word(CMD_LOAD_CTL, 0, 7, 0, 32'h8000_0000);
    send_word(CMD_LOAD_MEAS, 0, 7, 0, 32'h7FFF_FFFF);
    send_word(CMD_LOAD_MEAS, 0, 0, 0, 32'h8000_0000);
    send_word(CMD_LOAD_MAT, MID_H, 0, 0, 32'h0001_0000);
    send_word(CMD_LOAD_MAT, MID_R, 0, 0, 32'h7FFF_FFFF);
    send_word(CMD_STEP, 0, 0, 0, 0);

    // unused register index must be harmless
    drain();
    write_reg(CFG_UNUSED, 4'($urandom));

    // random phases over several sizes
    for (int ph = 0; ph < 9; ph++) begin
      set_sizes(plan[ph][0], plan[ph][1], plan[ph][2]);
      gaps_on = (ph != 1);
      run_phase(33);
    end
    gaps_on = 1;

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_states.size() == 0)
      $display("linear_kalman_filter_step test passed");
    else
      $display("linear_kalman_filter_step test failed");
    $finish;
  end

endmodule
